// File: design/mcr_pkg.sv
// shared types and constants of the midpoint circle rasterizer
// used by mcr_front, mcr_queue, mcr_back and midpoint_circle_rasterizer

package mcr_pkg;

	// request kinds carried in the slave-side tuser
	localparam logic REQ_START = 1'b0;
	localparam logic REQ_STEP  = 1'b1;

	// configuration register indexes
	localparam logic CFG_CENTER_X = 1'b0;
	localparam logic CFG_CENTER_Y = 1'b1;

	localparam int CFG_W     = 10;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_W-1:0] CENTER_X_RST = 10'd320;
	localparam logic [CFG_W-1:0] CENTER_Y_RST = 10'd240;

	// pixel word layout
	localparam int PIX_W     = 12;
	localparam int COLOR_W   = 4;
	localparam int OUT_DATA_W = 32;

	// decision arithmetic constants
	localparam int DEC_INIT    = 3;
	localparam int DEC_ADD_NEG = 6;
	localparam int DEC_ADD_POS = 10;

	// step record queue
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	localparam int OCT_W = 3;
	localparam logic [OCT_W-1:0] OCT_LAST = 3'd7;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// colour code per octant in emission order
	function automatic logic [COLOR_W-1:0] oct_color(input logic [OCT_W-1:0] k);
		logic [COLOR_W-1:0] c;
		case (k)
			3'd0: c = 4'd1;
			3'd1: c = 4'd2;
			3'd2: c = 4'd3;
			3'd3: c = 4'd5;
			3'd4: c = 4'd6;
			3'd5: c = 4'd7;
			3'd6: c = 4'd8;
			default: c = 4'd9;
		endcase
		return c;
	endfunction

	// octants four and up swap the roles of x and y
	function automatic logic oct_swap(input logic [OCT_W-1:0] k);
		return k[2];
	endfunction

	// horizontal offset is subtracted
	function automatic logic oct_neg_x(input logic [OCT_W-1:0] k);
		logic n;
		case (k)
			3'd1, 3'd3, 3'd6, 3'd7: n = 1'b1;
			default: n = 1'b0;
		endcase
		return n;
	endfunction

	// vertical offset is subtracted
	function automatic logic oct_neg_y(input logic [OCT_W-1:0] k);
		logic n;
		case (k)
			3'd2, 3'd3, 3'd5, 3'd7: n = 1'b1;
			default: n = 1'b0;
		endcase
		return n;
	endfunction

endpackage

// File: design/mcr_front.sv
// front end: accepts start and step words, runs the midpoint decision
// and pushes one step record {done, y, x} per active step; uses mcr_pkg

module mcr_front #(
	parameter int RADIUS_BITS = 10,
	parameter int REC_W = 2 * RADIUS_BITS + 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  logic                   req_type,
	input  logic [RADIUS_BITS-1:0] radius,
	output logic                   push,
	output logic [REC_W-1:0]       rec
);

	localparam int RB = RADIUS_BITS;
	localparam int DW = RADIUS_BITS + 4;
	localparam int XW = RADIUS_BITS + 1;

	logic [RB-1:0] x_q, y_q;
	logic [DW-1:0] d_q;
	logic          active_q;

	logic          step;
	logic          neg;
	logic [DW-1:0] dx, dy, d_neg, d_pos;
	logic [XW-1:0] x_ext, x_inc, y_ext;
	logic          done;

	assign step = accept && (req_type == mcr_pkg::REQ_STEP) && active_q;
	assign push = step;
	assign neg  = d_q[DW-1];

	always_comb begin
		dx    = DW'(x_q);
		dy    = DW'(y_q);
		d_neg = d_q + (dx << 2) + DW'(mcr_pkg::DEC_ADD_NEG);
		d_pos = d_q + ((dx - dy) << 2) + DW'(mcr_pkg::DEC_ADD_POS);
		x_ext = XW'(x_q);
		y_ext = XW'(y_q);
		x_inc = x_ext + XW'(1);
		// updated x exceeds updated y
		done  = neg ? (x_ext >= y_ext) : (x_inc >= y_ext);
	end

	assign rec = {done, y_q, x_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			x_q      <= '0;
			y_q      <= '0;
			d_q      <= '0;
		end else if (accept && (req_type == mcr_pkg::REQ_START)) begin
			active_q <= 1'b1;
			x_q      <= '0;
			y_q      <= radius;
			d_q      <= DW'(mcr_pkg::DEC_INIT) - (DW'(radius) << 1);
		end else if (step) begin
			x_q <= x_q + RB'(1);
			if (neg) begin
				d_q <= d_neg;
			end else begin
				d_q <= d_pos;
				y_q <= y_q - RB'(1);
			end
			if (done) begin
				active_q <= 1'b0;
			end
		end
	end

endmodule

// File: design/mcr_queue.sv
// short fifo of step records between front and back end
// depth and pointer widths from mcr_pkg

module mcr_queue #(
	parameter int W = 21
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [W-1:0]      wdata,
	input  logic              pop,
	output logic [W-1:0]      rdata,
	output mcr_pkg::q_status_t status
);

	logic [W-1:0] mem_q [mcr_pkg::QDEPTH];
	logic [mcr_pkg::QPTR_W-1:0] wr_q, rd_q;
	logic [mcr_pkg::QCNT_W-1:0] cnt_q;

	logic do_push, do_pop;

	assign status.full  = (cnt_q == mcr_pkg::QCNT_W'(mcr_pkg::QDEPTH));
	assign status.empty = (cnt_q == '0);
	assign do_push = push && !status.full;
	assign do_pop  = pop && !status.empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + mcr_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + mcr_pkg::QPTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10: cnt_q <= cnt_q + mcr_pkg::QCNT_W'(1);
				2'b01: cnt_q <= cnt_q - mcr_pkg::QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: design/mcr_back.sv
// back end: expands each step record into eight octant pixels,
// one per cycle into the output register unless the pixel side stalls; uses mcr_pkg

module mcr_back #(
	parameter int RADIUS_BITS = 10,
	parameter int REC_W = 2 * RADIUS_BITS + 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [REC_W-1:0]             rec,
	input  logic                         rec_valid,
	output logic                         pop,
	input  logic [mcr_pkg::CFG_W-1:0]    center_x,
	input  logic [mcr_pkg::CFG_W-1:0]    center_y,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [mcr_pkg::PIX_W-1:0]    pixel_x,
	output logic [mcr_pkg::PIX_W-1:0]    pixel_y,
	output logic [mcr_pkg::COLOR_W-1:0]  color,
	output logic                         last_of_step,
	output logic                         circle_done
);

	localparam int RB = RADIUS_BITS;
	localparam int PW = mcr_pkg::PIX_W;

	logic [mcr_pkg::OCT_W-1:0] k_q;
	logic                      valid_q;
	logic [PW-1:0]             px_q, py_q;
	logic [mcr_pkg::COLOR_W-1:0] color_q;
	logic                      last_q, done_q;

	logic [RB-1:0] rx, ry;
	logic          rdone;
	logic          load, is_last;
	logic [PW-1:0] off_x, off_y, cx, cy, px, py;

	assign {rdone, ry, rx} = rec;
	assign load    = rec_valid && (!valid_q || out_ready);
	assign is_last = (k_q == mcr_pkg::OCT_LAST);
	assign pop     = load && is_last;

	always_comb begin
		cx    = PW'(center_x);
		cy    = PW'(center_y);
		off_x = mcr_pkg::oct_swap(k_q) ? PW'(ry) : PW'(rx);
		off_y = mcr_pkg::oct_swap(k_q) ? PW'(rx) : PW'(ry);
		px    = mcr_pkg::oct_neg_x(k_q) ? (cx - off_x) : (cx + off_x);
		py    = mcr_pkg::oct_neg_y(k_q) ? (cy - off_y) : (cy + off_y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			k_q     <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				k_q     <= k_q + mcr_pkg::OCT_W'(1);
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			px_q    <= px;
			py_q    <= py;
			color_q <= mcr_pkg::oct_color(k_q);
			last_q  <= is_last;
			done_q  <= is_last && rdone;
		end
	end

	assign out_valid    = valid_q;
	assign pixel_x      = px_q;
	assign pixel_y      = py_q;
	assign color        = color_q;
	assign last_of_step = last_q;
	assign circle_done  = done_q;

endmodule

// File: design/midpoint_circle_rasterizer.sv
// midpoint circle rasterizer top level: front end, record queue, back end
// a start word yields no pixels; a step word of an active circle yields eight
// pixel words, one per cycle unless m_tready stalls, once its record has passed
// the queue; the sustained step rate is set by the back end's single pixel
// output register, and the front end runs ahead by up to four steps
// arst_n clears all control state, the centre resets to (320, 240)

module midpoint_circle_rasterizer #(
	parameter int RADIUS_BITS = 10
) (
	input  logic clk,
	input  logic arst_n,

	// request side
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [((RADIUS_BITS+7)/8)*8-1:0] s_tdata,  // radius, zero padded
	input  logic                          s_tuser,  // req_type

	// pixel side
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [mcr_pkg::OUT_DATA_W-1:0] m_tdata, // pixel_x, pixel_y, color, zero pad
	output logic                          m_tlast,  // last_of_step
	output logic                          m_tuser,  // circle_done

	// configuration write port
	input  logic                          cfg_we,
	input  logic [mcr_pkg::CFG_IDX_W-1:0] cfg_addr,
	input  logic [mcr_pkg::CFG_W-1:0]     cfg_wdata
);

	localparam int REC_W = 2 * RADIUS_BITS + 1;
	localparam int PW = mcr_pkg::PIX_W;
	localparam int CW = mcr_pkg::COLOR_W;
	localparam int PAD_W = mcr_pkg::OUT_DATA_W - 2 * PW - CW;

	// centre registers: the user writes them only while the block is idle; the block does not enforce this
	logic [mcr_pkg::CFG_W-1:0] center_x_q, center_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= mcr_pkg::CENTER_X_RST;
			center_y_q <= mcr_pkg::CENTER_Y_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				mcr_pkg::CFG_CENTER_X: center_x_q <= cfg_wdata;
				mcr_pkg::CFG_CENTER_Y: center_y_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// front end takes a word whenever the queue has a free slot
	mcr_pkg::q_status_t q_status;
	logic               accept;
	logic               q_push, q_pop;
	logic [REC_W-1:0]   push_rec, head_rec;

	assign s_tready = !q_status.full;
	assign accept   = s_tvalid && s_tready;

	mcr_front #(
		.RADIUS_BITS(RADIUS_BITS),
		.REC_W      (REC_W)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.req_type(s_tuser),
		.radius  (s_tdata[RADIUS_BITS-1:0]),
		.push    (q_push),
		.rec     (push_rec)
	);

	// step records wait here so the front end is not held by the pixel side until the queue is full
	mcr_queue #(
		.W(REC_W)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata (push_rec),
		.pop   (q_pop),
		.rdata (head_rec),
		.status(q_status)
	);

	// eight octant pixels per record
	logic [PW-1:0] pixel_x, pixel_y;
	logic [CW-1:0] color;

	mcr_back #(
		.RADIUS_BITS(RADIUS_BITS),
		.REC_W      (REC_W)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.rec         (head_rec),
		.rec_valid   (!q_status.empty),
		.pop         (q_pop),
		.center_x    (center_x_q),
		.center_y    (center_y_q),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.color       (color),
		.last_of_step(m_tlast),
		.circle_done (m_tuser)
	);

	assign m_tdata = {PAD_W'(0), color, pixel_y, pixel_x};

	// circle done only ever rides on the eighth pixel of a step
	a_done_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("circle done flagged on a pixel that is not last of step");

	// the last pixel of a step always carries the final octant colour
	a_last_color: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> color == mcr_pkg::oct_color(mcr_pkg::OCT_LAST))
		else $error("last pixel of step has wrong octant colour");

	// the front end never pushes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_status.full)
		else $error("step record pushed into full queue");

	// a stalled pixel word holds its coordinates
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("pixel word changed while stalled");

endmodule

// File: dv/mcr_pixel_checker.sv
// pixel checker for the midpoint circle rasterizer: snoops the request, pixel and
// configuration ports, keeps its own copy of the circle state and compares pixels
// depends on mcr_pkg for port widths and register indexes
`timescale 1ns / 100ps

module mcr_pixel_checker #(
	parameter int RADIUS_BITS = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [((RADIUS_BITS+7)/8)*8-1:0] s_tdata,  // radius, zero padded
	input  logic                          s_tuser,  // req_type
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [mcr_pkg::OUT_DATA_W-1:0] m_tdata,  // pixel_x, pixel_y, color, zero pad
	input  logic                          m_tlast,  // last_of_step
	input  logic                          m_tuser,  // circle_done
	input  logic                          cfg_we,
	input  logic [mcr_pkg::CFG_IDX_W-1:0] cfg_addr,
	input  logic [mcr_pkg::CFG_W-1:0]     cfg_wdata,
	output int                            errors,
	output int                            outstanding,
	output int                            pixels_checked,
	output int                            circles_closed
);

	localparam int DEC_W = RADIUS_BITS + 4;
	localparam int PRINT_MAX = 40;
	localparam int PIX_W = mcr_pkg::PIX_W;
	localparam int COLOR_W = mcr_pkg::COLOR_W;

	typedef struct {
		logic [PIX_W-1:0]   px;
		logic [PIX_W-1:0]   py;
		logic [COLOR_W-1:0] color;
		logic               last;
		logic               done;
	} pixel_t;

	localparam logic [COLOR_W-1:0] OCT_COLOR [8] = '{4'd1, 4'd2, 4'd3, 4'd5,
		4'd6, 4'd7, 4'd8, 4'd9};

	logic [mcr_pkg::CFG_W-1:0] cen_x;
	logic [mcr_pkg::CFG_W-1:0] cen_y;
	int                      pos_x;
	int                      pos_y;
	logic signed [DEC_W-1:0] decision;
	logic                    circle_active;
	pixel_t                  pixel_exp[$];

	task automatic report_mismatch(input string field, input logic [PIX_W-1:0] got,
		input logic [PIX_W-1:0] want);
		if (errors < PRINT_MAX)
			$display("%0t pixel %0d: %s got %0h want %0h", $realtime, pixels_checked,
				field, got, want);
		errors++;
	endtask

	// one of the eight symmetric points about the centre
	function automatic pixel_t octant_pixel(input int k);
		pixel_t p;
		int     hx;
		int     vy;
		case (k)
			0: begin hx = int'(cen_x) + pos_x; vy = int'(cen_y) + pos_y; end
			1: begin hx = int'(cen_x) - pos_x; vy = int'(cen_y) + pos_y; end
			2: begin hx = int'(cen_x) + pos_x; vy = int'(cen_y) - pos_y; end
			3: begin hx = int'(cen_x) - pos_x; vy = int'(cen_y) - pos_y; end
			4: begin hx = int'(cen_x) + pos_y; vy = int'(cen_y) + pos_x; end
			5: begin hx = int'(cen_x) + pos_y; vy = int'(cen_y) - pos_x; end
			6: begin hx = int'(cen_x) - pos_y; vy = int'(cen_y) + pos_x; end
			default: begin hx = int'(cen_x) - pos_y; vy = int'(cen_y) - pos_x; end
		endcase
		p.px = PIX_W'(hx);
		p.py = PIX_W'(vy);
		p.color = OCT_COLOR[k];
		p.last = (k == 7);
		p.done = 1'b0;
		return p;
	endfunction

	// one step of the circle: eight pixels, then the decision update
	task automatic trace_step();
		pixel_t step_pix[8];
		if (!circle_active)
			return;
		for (int k = 0; k < 8; k++)
			step_pix[k] = octant_pixel(k);
		if (decision < 0) begin
			decision = DEC_W'(decision + 4 * pos_x + 6);
		end else begin
			decision = DEC_W'(decision + 4 * (pos_x - pos_y) + 10);
			pos_y--;
		end
		pos_x++;
		if (pos_x > pos_y) begin
			step_pix[7].done = 1'b1;
			circle_active = 1'b0;
		end
		for (int k = 0; k < 8; k++)
			pixel_exp.push_back(step_pix[k]);
	endtask

	task automatic check_pixel();
		pixel_t want;
		if (pixel_exp.size() == 0) begin
			if (errors < PRINT_MAX)
				$display("%0t unexpected pixel word %0h", $realtime, m_tdata);
			errors++;
			return;
		end
		want = pixel_exp.pop_front();
		if (m_tdata[PIX_W-1:0] !== want.px)
			report_mismatch("pixel_x", m_tdata[PIX_W-1:0], want.px);
		if (m_tdata[2*PIX_W-1:PIX_W] !== want.py)
			report_mismatch("pixel_y", m_tdata[2*PIX_W-1:PIX_W], want.py);
		if (m_tdata[2*PIX_W+COLOR_W-1:2*PIX_W] !== want.color)
			report_mismatch("color", PIX_W'(m_tdata[2*PIX_W+COLOR_W-1:2*PIX_W]),
				PIX_W'(want.color));
		if (m_tlast !== want.last)
			report_mismatch("last_of_step", PIX_W'(m_tlast), PIX_W'(want.last));
		if (m_tuser !== want.done)
			report_mismatch("circle_done", PIX_W'(m_tuser), PIX_W'(want.done));
		if (want.done)
			circles_closed++;
		pixels_checked++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cen_x = mcr_pkg::CENTER_X_RST;
			cen_y = mcr_pkg::CENTER_Y_RST;
			pos_x = 0;
			pos_y = 0;
			decision = '0;
			circle_active = 1'b0;
			pixel_exp.delete();
			errors = 0;
			pixels_checked = 0;
			circles_closed = 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					mcr_pkg::CFG_CENTER_X: cen_x = cfg_wdata;
					mcr_pkg::CFG_CENTER_Y: cen_y = cfg_wdata;
					default: ;
				endcase
			end
			if (m_tvalid && m_tready)
				check_pixel();
			if (s_tvalid && s_tready) begin
				if (s_tuser == mcr_pkg::REQ_START) begin
					pos_x = 0;
					pos_y = int'(s_tdata[RADIUS_BITS-1:0]);
					decision = DEC_W'(3 - 2 * pos_y);
					circle_active = 1'b1;
				end else begin
					trace_step();
				end
			end
			outstanding <= pixel_exp.size();
		end
	end

endmodule

// File: dv/testbench.sv
// top of the midpoint circle rasterizer regression: clock, reset, request and
// config stimulus, random pixel back-pressure; checking sits in mcr_pixel_checker
`timescale 1ns / 100ps

module testbench;

	localparam int RADIUS_BITS = 10;
	localparam int S_W = ((RADIUS_BITS + 7) / 8) * 8;
	localparam int CFG_W = mcr_pkg::CFG_W;
	localparam int CFG_IDX_W = mcr_pkg::CFG_IDX_W;
	localparam int CYCLE_LIMIT = 150000;  // far above the slowest legal run
	localparam int HOLD_CYCLES = 160;      // long receiver hold-off
	localparam int SETTLE_CYCLES = 24;     // idle margin after the last pixel is back
	localparam int RANDOM_WORDS = 66;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_W-1:0]       s_tdata = '0;
	logic                 s_tuser = mcr_pkg::REQ_START;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [mcr_pkg::OUT_DATA_W-1:0] m_tdata;
	logic                 m_tlast;
	logic                 m_tuser;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_addr = mcr_pkg::CFG_CENTER_X;
	logic [CFG_W-1:0]     cfg_wdata = '0;

	int errors;
	int outstanding;
	int pixels_checked;
	int circles_closed;

	// run bookkeeping
	int  cycle_count = 0;
	int  words_sent = 0;
	int  hold_asks = 0;
	int  holds_served = 0;
	bit  tx_steady = 1'b0;  // sender never idles while set
	bit  rx_steady = 1'b0;  // receiver never stalls while set

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	midpoint_circle_rasterizer #(.RADIUS_BITS(RADIUS_BITS)) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	mcr_pixel_checker #(.RADIUS_BITS(RADIUS_BITS)) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tlast       (m_tlast),
		.m_tuser       (m_tuser),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.errors        (errors),
		.outstanding   (outstanding),
		.pixels_checked(pixels_checked),
		.circles_closed(circles_closed)
	);

	// watchdog: a hung handshake or a lost pixel ends here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d pixels still owed", cycle_count,
				outstanding);
			$display("midpoint_circle_rasterizer regression: fail");
			$finish;
		end
	end

	// pixel side: random stall before every word, or a long hold-off on request
	initial begin : pixel_sink
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			if (holds_served != hold_asks) begin
				// long hold so the step record queue fills and s_tready drops
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				holds_served++;
			end else begin
				stall = rx_steady ? 0 : $urandom_range(0, 9);
				if (stall != 0) begin
					m_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
		end
	end

	// offer one request word; returns in the time step of its acceptance, valid
	// left high so a back-to-back word only changes the data
	task automatic send_word(input logic kind, input logic [RADIUS_BITS-1:0] radius);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= S_W'(radius);
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		words_sent++;
	endtask

	task automatic run_circle(input logic [RADIUS_BITS-1:0] radius, input int steps);
		send_word(mcr_pkg::REQ_START, radius);
		repeat (steps) send_word(mcr_pkg::REQ_STEP, RADIUS_BITS'($urandom));
	endtask

	// idle window for register writes: every pixel back, then a settle wait
	// in case a start or an ignored step is still in flight
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_center(input logic [CFG_W-1:0] hx, input logic [CFG_W-1:0] vy);
		write_reg(mcr_pkg::CFG_CENTER_X, hx);
		write_reg(mcr_pkg::CFG_CENTER_Y, vy);
	endtask

	// random traffic: mostly whole circles of small radius, some large radii cut
	// short, some circles broken off by a new start, and a few stray steps
	task automatic random_circles(input int quota);
		int n;
		int pick;
		int steps;
		logic [RADIUS_BITS-1:0] radius;
		n = 0;
		while (n < quota) begin
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				send_word(mcr_pkg::REQ_STEP, RADIUS_BITS'($urandom));
				n++;
			end else begin
				radius = (pick == 1) ? RADIUS_BITS'($urandom_range(0, 1023))
					: RADIUS_BITS'($urandom_range(0, 20));
				// about r / sqrt(2) + 1 steps close a circle
				steps = int'(radius) * 707 / 1000 + 1;
				if (steps > 16)
					steps = $urandom_range(1, 16);
				if (pick == 2)
					steps = $urandom_range(0, steps);
				run_circle(radius, steps);
				n += steps + 1;
				// now and then one more step, which must produce nothing if the circle has closed
				if ($urandom_range(0, 4) == 0) begin
					send_word(mcr_pkg::REQ_STEP, RADIUS_BITS'($urandom));
					n++;
				end
			end
		end
	endtask

	initial begin : stimulus
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset centre: stray step, zero radius, step after done,
		// radius one, a short full circle, a restart in the middle of a circle
		rx_steady = 1'b1;
		tx_steady = 1'b1;
		send_word(mcr_pkg::REQ_STEP, '1);
		run_circle('0, 2);
		run_circle(RADIUS_BITS'(1), 2);
		run_circle(RADIUS_BITS'(3), 4);
		run_circle(RADIUS_BITS'(5), 2);
		run_circle(RADIUS_BITS'(2), 3);
		drain();

		// centre at the origin: most octants land on negative coordinates
		rx_steady = 1'b0;
		tx_steady = 1'b0;
		set_center('0, '0);
		run_circle(RADIUS_BITS'(7), 6);
		drain();

		// centre at the far corner with the largest radius: coordinates span 0 to 2046
		set_center('1, '1);
		run_circle('1, 4);
		run_circle('0, 1);
		drain();

		// back-pressure: receiver holds off while the sender streams steps
		set_center(CFG_W'(512), CFG_W'(511));
		hold_asks++;
		tx_steady = 1'b1;
		run_circle(RADIUS_BITS'(20), 14);
		tx_steady = 1'b0;
		drain();

		// random phases, each with its own centre and idle pattern
		for (int phase = 0; phase < 3; phase++) begin
			set_center(CFG_W'($urandom), CFG_W'($urandom));
			rx_steady = (phase == 1);
			tx_steady = (phase == 2);
			random_circles(RANDOM_WORDS / 3);
			drain();
		end

		$display("sent %0d request words, checked %0d pixels, %0d circles closed",
			words_sent, pixels_checked, circles_closed);
		$display("centres at reset, both corners and random; one %0d-cycle pixel hold-off",
			HOLD_CYCLES);
		if (errors == 0)
			$display("midpoint_circle_rasterizer regression: pass");
		else
			$display("midpoint_circle_rasterizer regression: fail");
		$finish;
	end

endmodule
